>>> src/tvws_pkg.sv
// ----------------------------------------------------------------------------
// tvws_pkg
// shared constants, types and encodings of the three-voice sound generator
// ----------------------------------------------------------------------------
package tvws_pkg;

    // voice and wave memory geometry
    localparam int VOICE_COUNT  = 3;
    localparam int VOICE_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W        = $clog2(VOICE_COUNT + 1);
    localparam int TABLE_COUNT  = 4;
    localparam int TABLE_LENGTH = 64;
    localparam int TBL_W        = $clog2(TABLE_COUNT);
    localparam int OFF_W        = $clog2(TABLE_LENGTH);
    localparam int ADDR_W       = TBL_W + OFF_W;
    localparam int MEM_DEPTH    = TABLE_COUNT * TABLE_LENGTH;

    // command queue between front and back end
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // output slots of the result beat
    localparam int OUT_SLOTS    = 3;

    // per-voice register encodings
    localparam logic [3:0] NOISE_OFF  = 4'd8;
    localparam logic [4:0] NCLK_EVERY = 5'd16;
    localparam logic [7:0] TRI_MASK_NEG = 8'h7e;
    localparam logic [7:0] TRI_MASK_POS = 8'h80;

    // input item kinds
    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_WAVE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // register selects
    localparam logic [2:0] REG_STEP_LO   = 3'd0;
    localparam logic [2:0] REG_STEP_HI   = 3'd1;
    localparam logic [2:0] REG_VOLUME    = 3'd2;
    localparam logic [2:0] REG_TIMBRE    = 3'd3;
    localparam logic [2:0] REG_PHASE_LO  = 3'd4;
    localparam logic [2:0] REG_PHASE_HI  = 3'd5;
    localparam logic [2:0] REG_TIMBRE_EX = 3'd6;

    // timbre codes
    localparam logic [2:0] WV_TABLE0   = 3'd0;
    localparam logic [2:0] WV_TABLE1   = 3'd1;
    localparam logic [2:0] WV_TABLE2   = 3'd2;
    localparam logic [2:0] WV_TABLE3   = 3'd3;
    localparam logic [2:0] WV_FLAT     = 3'd4;
    localparam logic [2:0] WV_SAW      = 3'd5;
    localparam logic [2:0] WV_SQUARE   = 3'd6;
    localparam logic [2:0] WV_TRIANGLE = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_EXT_TABLES = 2'd0;
    localparam logic [1:0] CFG_SOUND_ON   = 2'd1;

    typedef enum logic [1:0] {
        OP_REG,
        OP_WAVE,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       voice;
        logic [2:0]       register_select;
        logic [TBL_W-1:0] table_select;
        logic [OFF_W-1:0] table_offset;
        logic [7:0]       data;
    } cmd_t;

    typedef struct packed {
        logic ext_tables;
        logic sound_on;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } back_state_t;

endpackage

>>> src/three_voice_wavetable_noise_synth_core.sv
// ----------------------------------------------------------------------------
// three_voice_wavetable_noise_synth_core
// three-voice wave-table / noise sound generator with command queue
// ----------------------------------------------------------------------------
// Input beats are voice register writes, wave memory byte writes or sample
// ticks; only a tick yields a result beat. The front end takes a beat in the
// cycle it arrives whenever the four-entry command queue has room, and drops
// beats with no effect (unused kind, unused register select, voice out of
// range). The back end takes one command per cycle while it is idle. A
// register or wave memory write is done as the command is taken. A tick
// with sound on holds the back end: the command is taken, each voice in
// turn passes through the single shared voice unit, the registered wave
// memory read and volume scaling of the last voice follow, and the result
// register is loaded. A tick with sound off bypasses the unit and shows zero
// samples with the current phases. A finished result waits in the output
// register while further beats queue up; the back end only stalls when a
// second tick is ready to be shown before the first was taken. Wave memory
// reads back as zero from reset on through per-entry valid bits, so there
// is no clearing pass. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module three_voice_wavetable_noise_synth_core
    import tvws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [1:0]  voice,
    input  logic [2:0]  register_select,
    input  logic [1:0]  table_select,
    input  logic [5:0]  table_offset,
    input  logic [7:0]  data,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] mix,
    output logic [13:0] voice0_sample,
    output logic [13:0] voice1_sample,
    output logic [13:0] voice2_sample,
    output logic [15:0] phase0,
    output logic [15:0] phase1,
    output logic [15:0] phase2,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    // configuration registers
    logic ext_tables_reg;
    logic sound_on_reg;
    cfg_t cfg;

    // queue hookup
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_out;

    // config writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_tables_reg <= 1'b0;
            sound_on_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // unknown indexes are ignored
            if (cfg_index == CFG_EXT_TABLES)
            begin
                ext_tables_reg <= cfg_data;
            end
            else if (cfg_index == CFG_SOUND_ON)
            begin
                sound_on_reg <= cfg_data;
            end
        end
    end

    assign cfg.ext_tables = ext_tables_reg;
    assign cfg.sound_on   = sound_on_reg;

    // accept and classify
    tvws_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .voice           (voice),
        .register_select (register_select),
        .table_select    (table_select),
        .table_offset    (table_offset),
        .data            (data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_in)
    );

    // decouples input acceptance from tick processing
    tvws_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .pop_cmd  (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    // voice state, wave memory, shared voice unit and result register
    tvws_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_cmd         (q_out),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mix           (mix),
        .voice0_sample (voice0_sample),
        .voice1_sample (voice1_sample),
        .voice2_sample (voice2_sample),
        .phase0        (phase0),
        .phase1        (phase1),
        .phase2        (phase2)
    );

endmodule

>>> src/tvws_front.sv
// ----------------------------------------------------------------------------
// tvws_front
// accepts input beats, drops the ones without effect and turns the rest
// into queue commands
// ----------------------------------------------------------------------------
module tvws_front
    import tvws_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [1:0] voice,
    input  logic [2:0] register_select,
    input  logic [1:0] table_select,
    input  logic [5:0] table_offset,
    input  logic [7:0] data,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic keep;
    op_t  op;

    always_comb
    begin
        keep = 1'b0;
        op   = OP_TICK;
        unique case (kind)
            KIND_REG:
            begin
                op   = OP_REG;
                keep = (32'(voice) < VOICE_COUNT) && (register_select <= REG_TIMBRE_EX);
            end
            KIND_WAVE:
            begin
                op   = OP_WAVE;
                keep = 1'b1;
            end
            KIND_TICK:
            begin
                op   = OP_TICK;
                keep = 1'b1;
            end
            default:
            begin
                op   = OP_TICK;
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready && keep;

    assign q_cmd.op              = op;
    assign q_cmd.voice           = voice;
    assign q_cmd.register_select = register_select;
    assign q_cmd.table_select    = TBL_W'(table_select);
    assign q_cmd.table_offset    = OFF_W'(table_offset);
    assign q_cmd.data            = data;

endmodule

>>> src/tvws_fifo.sv
// ----------------------------------------------------------------------------
// tvws_fifo
// short command queue between the front and back end
// ----------------------------------------------------------------------------
module tvws_fifo
    import tvws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    cmd_t              store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (32'(count_reg) == QUEUE_DEPTH);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/tvws_back.sv
// ----------------------------------------------------------------------------
// tvws_back
// executes queued commands: voice register writes, wave memory writes and
// sample ticks through one shared voice unit, plus the result register
// ----------------------------------------------------------------------------
module tvws_back
    import tvws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_empty,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [15:0]  mix,
    output logic [13:0]  voice0_sample,
    output logic [13:0]  voice1_sample,
    output logic [13:0]  voice2_sample,
    output logic [15:0]  phase0,
    output logic [15:0]  phase1,
    output logic [15:0]  phase2
);

    // sequencer
    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               calc_en;
    logic               load_out;
    logic               tick_pop;
    logic               reg_wr;
    logic               wave_wr;

    // per-voice state
    logic [15:0]        step_reg   [VOICE_COUNT];
    logic [15:0]        phase_reg  [VOICE_COUNT];
    logic [5:0]         mant_reg   [VOICE_COUNT];
    logic [2:0]         exp_reg    [VOICE_COUNT];
    logic [2:0]         choice_reg [VOICE_COUNT];
    logic [3:0]         ndepth_reg [VOICE_COUNT];
    logic [4:0]         nclk_reg   [VOICE_COUNT];
    logic [15:0]        lfsr_reg   [VOICE_COUNT];

    // wave memory, valid bits stand in for the reset clear
    logic [7:0]         wave_mem   [MEM_DEPTH];
    logic               wave_vld_reg [MEM_DEPTH];
    logic [7:0]         mem_q_reg;
    logic               vld_q_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    // voice unit, first step
    logic [VOICE_W-1:0] cv;
    logic [VOICE_W-1:0] rv;
    logic [15:0]        ph_old;
    logic [15:0]        ph_now;
    logic [15:0]        rise_bits;
    logic               lfsr_step;
    logic [15:0]        lfsr_new;
    logic signed [15:0] noise_mod;
    logic [15:0]        pos;

    // voice unit, second step
    logic               s_valid_reg;
    logic [VOICE_W-1:0] s_voice_reg;
    logic [7:0]         s_hi_reg;
    logic [2:0]         s_choice_reg;
    logic [5:0]         s_mant_reg;
    logic [2:0]         s_exp_reg;
    logic signed [7:0]  raw;
    logic signed [7:0]  entry;
    logic [7:0]         tri_byte;
    logic signed [14:0] raw_x;
    logic signed [14:0] mant_x;
    logic signed [14:0] prod;
    logic signed [14:0] scaled;
    logic [13:0]        sample;

    // tick accumulation and result register
    logic [15:0]        acc_reg;
    logic [13:0]        smp_reg    [OUT_SLOTS];
    logic [15:0]        ph_src     [OUT_SLOTS];
    logic               out_valid_reg;
    logic [15:0]        out_mix_reg;
    logic [13:0]        out_smp_reg [OUT_SLOTS];
    logic [15:0]        out_ph_reg  [OUT_SLOTS];

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && q_cmd.op == OP_TICK)
                begin
                    state_next = cfg.sound_on ? ST_RUN : ST_OUT;
                end
            end
            ST_RUN:
            begin
                if (32'(cnt_reg) >= VOICE_COUNT)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        calc_en  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_RUN:
            begin
                calc_en = (32'(cnt_reg) < VOICE_COUNT);
            end
            ST_OUT:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign tick_pop = q_pop && (q_cmd.op == OP_TICK);
    assign reg_wr   = q_pop && (q_cmd.op == OP_REG);
    assign wave_wr  = q_pop && (q_cmd.op == OP_WAVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s_valid_reg <= calc_en;
            if (tick_pop)
            begin
                cnt_reg <= '0;
            end
            else if (calc_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // voice unit, first step: phase, noise generator, lookup position
    // ------------------------------------------------------------------
    assign cv = cnt_reg[VOICE_W-1:0];
    assign rv = VOICE_W'(q_cmd.voice);

    always_comb
    begin
        ph_old    = phase_reg[cv];
        ph_now    = ph_old + step_reg[cv];
        rise_bits = ph_now & ~ph_old;
        lfsr_step = nclk_reg[cv][4] || rise_bits[nclk_reg[cv][3:0]];
        lfsr_new  = lfsr_step ? {lfsr_reg[cv][3] ^ lfsr_reg[cv][0], lfsr_reg[cv][15:1]}
                              : lfsr_reg[cv];
        noise_mod = ndepth_reg[cv][3] ? 16'sd0
                                      : ($signed(lfsr_new) >>> ndepth_reg[cv][2:0]);
        pos       = ph_now + noise_mod;
        rd_addr   = {choice_reg[cv][TBL_W-1:0], pos[15 -: OFF_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                step_reg[i]   <= '0;
                phase_reg[i]  <= '0;
                mant_reg[i]   <= '0;
                exp_reg[i]    <= '0;
                choice_reg[i] <= '0;
                ndepth_reg[i] <= NOISE_OFF;
                nclk_reg[i]   <= NCLK_EVERY;
                lfsr_reg[i]   <= 16'd1;
            end
        end
        else if (reg_wr)
        begin
            unique case (q_cmd.register_select)
                REG_STEP_LO:   step_reg[rv][7:0]   <= q_cmd.data;
                REG_STEP_HI:   step_reg[rv][15:8]  <= q_cmd.data;
                REG_VOLUME:
                begin
                    mant_reg[rv] <= {1'b1, q_cmd.data[3:1], 2'b00};
                    exp_reg[rv]  <= q_cmd.data[6:4];
                end
                REG_TIMBRE:
                begin
                    choice_reg[rv] <= q_cmd.data[2:0];
                    ndepth_reg[rv] <= q_cmd.data[7] ? {1'b0, ~q_cmd.data[6:4]} : NOISE_OFF;
                end
                REG_PHASE_LO:  phase_reg[rv][7:0]  <= q_cmd.data;
                REG_PHASE_HI:  phase_reg[rv][15:8] <= q_cmd.data;
                REG_TIMBRE_EX:
                begin
                    nclk_reg[rv] <= q_cmd.data[7] ? {1'b0, q_cmd.data[7:4]} : NCLK_EVERY;
                end
                default:
                begin
                    step_reg[rv] <= step_reg[rv];
                end
            endcase
        end
        else if (calc_en)
        begin
            phase_reg[cv] <= ph_now;
            lfsr_reg[cv]  <= lfsr_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_en)
        begin
            s_voice_reg  <= cv;
            s_hi_reg     <= pos[15:8];
            s_choice_reg <= choice_reg[cv];
            s_mant_reg   <= mant_reg[cv];
            s_exp_reg    <= exp_reg[cv];
        end
    end

    // ------------------------------------------------------------------
    // wave memory
    // ------------------------------------------------------------------
    assign wr_addr = {q_cmd.table_select, q_cmd.table_offset};

    always_ff @(posedge clk)
    begin
        if (wave_wr)
        begin
            wave_mem[wr_addr] <= q_cmd.data;
        end
        mem_q_reg <= wave_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                wave_vld_reg[i] <= 1'b0;
            end
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wave_wr)
            begin
                wave_vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= wave_vld_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // voice unit, second step: raw sample and volume scaling
    // ------------------------------------------------------------------
    always_comb
    begin
        entry    = vld_q_reg ? $signed(mem_q_reg ^ TRI_MASK_POS) : -8'sd128;
        tri_byte = {s_hi_reg[6:0], 1'b0} ^ (s_hi_reg[7] ? TRI_MASK_NEG : TRI_MASK_POS);
        unique case (s_choice_reg)
            WV_TABLE0:   raw = entry;
            WV_TABLE1:   raw = entry;
            WV_TABLE2:   raw = cfg.ext_tables ? entry : 8'sd0;
            WV_TABLE3:   raw = cfg.ext_tables ? entry : 8'sd0;
            WV_FLAT:     raw = -8'sd1;
            WV_SAW:      raw = $signed(s_hi_reg);
            WV_SQUARE:   raw = s_hi_reg[7] ? -8'sd128 : 8'sd127;
            WV_TRIANGLE: raw = $signed(tri_byte);
            default:     raw = -8'sd1;
        endcase
        raw_x  = 15'(raw);
        mant_x = 15'($signed({1'b0, s_mant_reg}));
        prod   = raw_x * mant_x;
        scaled = prod >>> s_exp_reg;
        sample = scaled[13:0];
    end

    always_ff @(posedge clk)
    begin
        if (tick_pop)
        begin
            acc_reg <= '0;
            for (int i = 0; i < OUT_SLOTS; i++)
            begin
                smp_reg[i] <= '0;
            end
        end
        else if (s_valid_reg)
        begin
            acc_reg <= acc_reg + 16'($signed(sample));
            for (int i = 0; i < OUT_SLOTS; i++)
            begin
                if (32'(s_voice_reg) == i)
                begin
                    smp_reg[i] <= sample;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    for (genvar g = 0; g < OUT_SLOTS; g++)
    begin : g_slot
        if (g < VOICE_COUNT)
        begin : g_live
            assign ph_src[g] = phase_reg[g];
        end
        else
        begin : g_absent
            assign ph_src[g] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_mix_reg <= acc_reg;
            for (int i = 0; i < OUT_SLOTS; i++)
            begin
                out_smp_reg[i] <= smp_reg[i];
                out_ph_reg[i]  <= ph_src[i];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign mix           = out_mix_reg;
    assign voice0_sample = out_smp_reg[0];
    assign voice1_sample = out_smp_reg[1];
    assign voice2_sample = out_smp_reg[2];
    assign phase0        = out_ph_reg[0];
    assign phase1        = out_ph_reg[1];
    assign phase2        = out_ph_reg[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_scale_follows_calc: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> $past(calc_en))
        else $error("scale step without a preceding voice step");

    a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> !s_valid_reg)
        else $error("result loaded before last voice was scaled");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (32'(cnt_reg) <= VOICE_COUNT))
        else $error("voice counter ran past the last voice");

endmodule
